>>> src/gof_pkg.sv
// Shared types and command codes for the glyph outline flattener.
package gof_pkg;

    // Command kinds carried on the input tuser
    localparam logic [1:0] KIND_MOVE  = 2'd0;
    localparam logic [1:0] KIND_LINE  = 2'd1;
    localparam logic [1:0] KIND_CURVE = 2'd2;
    localparam logic [1:0] KIND_CUBIC = 2'd3;

    // Segment index width, covers segment counts up to 31
    localparam int JW = 5;

    // Reset value of the scale register: 1.0 in Q8.16
    localparam logic [23:0] SCALE_RESET = 24'd65536;

    typedef struct packed {
        logic          load;    // latch command coordinates, update previous point
        logic          issue;   // push one point into the pipeline
        logic          starts;  // point opens a contour
        logic          last;    // final point of the command
        logic [JW-1:0] j;       // curve parameter index, t = j / SEGMENTS
    } gof_cmd_t;

    typedef struct packed {
        logic have_point;       // a command with points was accepted since reset
        logic advance;          // pipeline moves this cycle
    } gof_stat_t;

endpackage

>>> src/gof_ctrl.sv
// Command sequencer: accepts commands and issues one curve point per step.
module gof_ctrl #(
    parameter int SEGMENTS = 5
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [1:0]        kind,
    input  gof_pkg::gof_stat_t stat,
    output gof_pkg::gof_cmd_t  cmd
);
    import gof_pkg::*;

    localparam logic [JW-1:0] J_LAST = JW'(SEGMENTS);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_ISSUE = 2'b10
    } state_t;

    state_t        state_reg, state_next;
    logic [JW-1:0] j_reg, j_next;
    logic          start_reg, start_next;

    always_comb
    begin
        state_next = state_reg;
        j_next     = j_reg;
        start_next = start_reg;
        cmd        = '0;
        cmd.j      = j_reg;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (kind inside {KIND_MOVE, KIND_LINE})
                    begin
                        // a move or line is the curve point at t = 1
                        cmd.load   = 1'b1;
                        j_next     = J_LAST;
                        start_next = (kind == KIND_MOVE) || !stat.have_point;
                        state_next = ST_ISSUE;
                    end
                    else if (kind == KIND_CURVE)
                    begin
                        cmd.load   = 1'b1;
                        j_next     = JW'(1);
                        start_next = !stat.have_point;
                        state_next = ST_ISSUE;
                    end
                end
            end
            ST_ISSUE:
            begin
                if (stat.advance)
                begin
                    cmd.issue  = 1'b1;
                    cmd.starts = start_reg;
                    cmd.last   = (j_reg == J_LAST);
                    start_next = 1'b0;
                    j_next     = j_reg + JW'(1);
                    if (j_reg == J_LAST)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            j_reg     <= '0;
            start_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            j_reg     <= j_next;
            start_reg <= start_next;
        end
    end

endmodule

>>> src/gof_datapath.sv
// Point pipeline: Bezier weighting, scaling and floor division by SEGMENTS^2.
module gof_datapath #(
    parameter int SEGMENTS = 5
) (
    input  logic               clk,
    input  logic               rst_n,
    input  gof_pkg::gof_cmd_t  cmd,
    output gof_pkg::gof_stat_t stat,
    input  logic signed [15:0] end_x,
    input  logic signed [15:0] end_y,
    input  logic signed [15:0] ctrl_x,
    input  logic signed [15:0] ctrl_y,
    input  logic               cfg_we,
    input  logic [23:0]        cfg_wdata,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [79:0]        m_tdata,
    output logic               m_tuser,
    output logic               m_tlast
);
    import gof_pkg::*;

    localparam int NST = 9;
    localparam int DIV = SEGMENTS * SEGMENTS;
    // floor(n / DIV) == (n * RECIP) >> 32 for every n below 2^24
    localparam logic [32:0] RECIP = 33'(((64'd1 << 32) + 64'(DIV) - 64'd1) / 64'(DIV));
    localparam logic signed [26:0] BIAS = 27'(32768 * DIV);
    localparam logic [8:0] DIV_W = 9'(DIV);
    localparam logic [JW-1:0] SEG_J = JW'(SEGMENTS);

    logic [23:0] scale_reg;
    logic        have_reg;
    logic signed [15:0] prev_reg [2];
    logic signed [15:0] p0_reg [2];
    logic signed [15:0] c_reg  [2];
    logic signed [15:0] e_reg  [2];
    logic signed [15:0] end_v  [2];
    logic signed [15:0] ctrl_v [2];

    logic [NST-1:0] vld_reg;
    logic [NST-1:0] st_reg;
    logic [NST-1:0] lt_reg;
    logic           en;

    // stage 0: weights and coordinates
    logic [8:0] wa_reg, wb_reg, wc_reg;
    logic [8:0] wa_next, wb_next, wc_next;
    logic [8:0] sj_w, j_w;
    logic signed [15:0] s0p_reg [2];
    logic signed [15:0] s0c_reg [2];
    logic signed [15:0] s0e_reg [2];
    // stages 1..8
    logic [23:0]        wp1_reg [2];
    logic [23:0]        wp2_reg [2];
    logic [56:0]        p2_reg  [2];
    logic signed [15:0] q3_reg  [2];
    logic [7:0]         r3_reg  [2];
    logic signed [39:0] m4_reg  [2];
    logic [31:0]        t4_reg  [2];
    logic signed [39:0] m5_reg  [2];
    logic [48:0]        ph5_reg [2];
    logic [15:0]        th5_reg [2];
    logic [15:0]        tl5_reg [2];
    logic signed [39:0] m6_reg  [2];
    logic [15:0]        qh6_reg [2];
    logic [23:0]        n6_reg  [2];
    logic signed [39:0] m7_reg  [2];
    logic [15:0]        qh7_reg [2];
    logic [56:0]        pl7_reg [2];
    logic signed [39:0] out_reg [2];

    logic signed [26:0] wsum [2];
    logic [15:0]        q3_u [2];
    logic [23:0]        r3_d [2];
    logic [15:0]        qh_u [2];
    logic [15:0]        rh_d [2];

    assign end_v[0]  = end_x;
    assign end_v[1]  = end_y;
    assign ctrl_v[0] = ctrl_x;
    assign ctrl_v[1] = ctrl_y;

    assign en              = !vld_reg[NST-1] || m_tready;
    assign stat.advance    = en;
    assign stat.have_point = have_reg;

    assign m_tvalid = vld_reg[NST-1];
    assign m_tdata  = {out_reg[1], out_reg[0]};
    assign m_tuser  = st_reg[NST-1];
    assign m_tlast  = lt_reg[NST-1];

    // Bernstein weights scaled by SEGMENTS^2
    always_comb
    begin
        j_w     = 9'(cmd.j);
        sj_w    = 9'(SEG_J - cmd.j);
        wa_next = sj_w * sj_w;
        wb_next = (sj_w * j_w) << 1;
        wc_next = j_w * j_w;
    end

    always_comb
    begin
        for (int k = 0; k < 2; k++)
        begin
            // bias keeps the weighted sum non-negative
            wsum[k] = $signed({1'b0, wa_reg}) * s0p_reg[k]
                    + $signed({1'b0, wb_reg}) * s0c_reg[k]
                    + $signed({1'b0, wc_reg}) * s0e_reg[k] + BIAS;
            q3_u[k] = p2_reg[k][47:32];
            r3_d[k] = wp2_reg[k] - 24'(q3_u[k]) * 24'(DIV_W);
            qh_u[k] = ph5_reg[k][47:32];
            rh_d[k] = th5_reg[k] - 16'(qh_u[k] * DIV_W);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= SCALE_RESET;
            have_reg  <= 1'b0;
            prev_reg  <= '{default: '0};
            vld_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                scale_reg <= cfg_wdata;
            end
            if (cmd.load)
            begin
                have_reg <= 1'b1;
                for (int k = 0; k < 2; k++)
                begin
                    prev_reg[k] <= end_v[k];
                end
            end
            if (en)
            begin
                vld_reg <= {vld_reg[NST-2:0], cmd.issue};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int k = 0; k < 2; k++)
            begin
                // curve with no prior point starts at the origin
                p0_reg[k] <= have_reg ? prev_reg[k] : 16'sd0;
                c_reg[k]  <= ctrl_v[k];
                e_reg[k]  <= end_v[k];
            end
        end
        if (en)
        begin
            st_reg <= {st_reg[NST-2:0], cmd.starts};
            lt_reg <= {lt_reg[NST-2:0], cmd.last};
            wa_reg <= wa_next;
            wb_reg <= wb_next;
            wc_reg <= wc_next;
            for (int k = 0; k < 2; k++)
            begin
                s0p_reg[k] <= p0_reg[k];
                s0c_reg[k] <= c_reg[k];
                s0e_reg[k] <= e_reg[k];
                wp1_reg[k] <= wsum[k][23:0];
                wp2_reg[k] <= wp1_reg[k];
                p2_reg[k]  <= 57'(wp1_reg[k]) * 57'(RECIP);
                // quotient minus the bias in raw units: flip the top bit
                q3_reg[k]  <= $signed({~q3_u[k][15], q3_u[k][14:0]});
                r3_reg[k]  <= r3_d[k][7:0];
                m4_reg[k]  <= q3_reg[k] * $signed({1'b0, scale_reg});
                t4_reg[k]  <= 32'(r3_reg[k]) * 32'(scale_reg);
                m5_reg[k]  <= m4_reg[k];
                ph5_reg[k] <= 49'(t4_reg[k][31:16]) * 49'(RECIP);
                th5_reg[k] <= t4_reg[k][31:16];
                tl5_reg[k] <= t4_reg[k][15:0];
                m6_reg[k]  <= m5_reg[k];
                qh6_reg[k] <= qh_u[k];
                n6_reg[k]  <= {rh_d[k][7:0], tl5_reg[k]};
                m7_reg[k]  <= m6_reg[k];
                qh7_reg[k] <= qh6_reg[k];
                pl7_reg[k] <= 57'(n6_reg[k]) * 57'(RECIP);
                out_reg[k] <= m7_reg[k] + $signed({8'd0, qh7_reg[k], pl7_reg[k][47:32]});
            end
        end
    end

endmodule

>>> src/glyph_outline_flattener_top.sv
// Glyph outline flattener: outline commands in, scaled outline points out.
//
// Input stream: s_tdata = {ctrl_y, ctrl_x, end_y, end_x} (16-bit signed each),
// s_tuser = command kind (move, line, quadratic curve, cubic).
// Output stream: one word per point, m_tdata = {point_y, point_x} (40-bit signed
// Q24.16), m_tuser = starts_contour, m_tlast = final point of the command.
// cfg_we / cfg_wdata write the 24-bit Q8.16 scale; write it only while idle.
//
// Move and line give one point, a curve SEGMENTS points, a cubic none.
// A command is taken, then its points are issued one per cycle, while the
// output is not stalled, into a 9-stage pipeline (weighting, two reciprocal
// divides, scaling, final add); the input waits while a command's points
// are being issued.
// A stalled output freezes the whole pipeline; nothing is dropped.
// Reset clears the pipeline, the previous point and sets scale to 1.0.
module glyph_outline_flattener_top #(
    parameter int SEGMENTS = 5
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // end_x, end_y, ctrl_x, ctrl_y
    input  logic [1:0]  s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // point_x, point_y
    output logic        m_tuser,   // starts_contour
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [23:0] cfg_wdata
);
    import gof_pkg::*;

    gof_cmd_t  cmd;
    gof_stat_t stat;

    gof_ctrl #(
        .SEGMENTS (SEGMENTS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .kind     (s_tuser),
        .stat     (stat),
        .cmd      (cmd)
    );

    gof_datapath #(
        .SEGMENTS (SEGMENTS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .end_x     ($signed(s_tdata[15:0])),
        .end_y     ($signed(s_tdata[31:16])),
        .ctrl_x    ($signed(s_tdata[47:32])),
        .ctrl_y    ($signed(s_tdata[63:48])),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

>>> src/gof_checker.sv
// Port-level checks for the glyph outline flattener, bound to the top level.
module gof_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [79:0] m_tdata,
    input logic        m_tlast
);
    import gof_pkg::*;

    // stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed under stall");

    // a command with points blocks the input while it issues
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == KIND_MOVE || s_tuser == KIND_LINE ||
        s_tuser == KIND_CURVE) |=> !s_tready)
        else $error("input taken while a command was issuing");

    // cubic is dropped at once
    a_cubic: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser == KIND_CUBIC |=> s_tready)
        else $error("cubic command held the input");

    // points of one command leave back to back
    a_burst: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("gap inside a command's points");

endmodule

bind glyph_outline_flattener_top gof_checker u_gof_checker (.*);
